>>> hdl/assert_macros.svh
// Assertion macros shared by the odometry RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

>>> hdl/ddo_pkg.sv
// Types, constants and helper functions of the differential drive odometry.
// No dependencies; used by the two interfaces and the odometry top level.
package ddo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [31:0] COUNT_MAX = 32'sh7fff_ffff;
  localparam logic [31:0] TWO_PI_Q16 = 32'd411775;
  localparam logic signed [20:0] TWO_PI_Q16_S = 21'sd411775;
  localparam logic signed [20:0] PI_Q16 = 21'sd205887;
  localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] GAIN_Q30 = 35'sd652032874;
  localparam logic signed [32:0] US_PER_S = 33'sd1000000;
  localparam logic [31:0] MPT_RESET = 32'd65536;
  localparam logic [23:0] IWB_RESET = 24'd131072;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_METERS_PER_TICK = 1'b0,
    REG_INV_WHEEL_BASE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_UPDATED   = 2'd0,
    STATUS_INVALID   = 2'd1,
    STATUS_NO_MOTION = 2'd2,
    STATUS_ZERO_DT   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_DL, ST_DR, ST_DTH,
    ST_LIN_M, ST_LIN_D, ST_ANG_M, ST_ANG_D,
    ST_MOD_D, ST_ROT_D, ST_MOD_H, ST_ROT_H,
    ST_DX, ST_DY, ST_SX_M, ST_SX_D, ST_SY_M, ST_SY_D,
    ST_PXC, ST_PXS, ST_PYS, ST_PYC, ST_HEAD, ST_EMIT
  } state_t;

  typedef struct packed {
    logic               command;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [31:0]        time_stamp;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] speed_linear;
    logic signed [31:0] speed_angular;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    status_t            status;
  } result_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // sign and magnitude to a saturated 32-bit value
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [51:0] m);
    logic signed [31:0] r;
    if (m >= 52'h0_0000_8000_0000) begin
      r = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = neg ? -$signed(m[31:0]) : $signed(m[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32_s(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sh00_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < -40'sh00_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/ddo_sample_if.sv
// Input channel of the odometry: valid/ready handshake with one sample per beat.
// Depends on ddo_pkg for the payload type.
interface ddo_sample_if;
  logic             valid;
  logic             ready;
  ddo_pkg::sample_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

>>> hdl/ddo_result_if.sv
// Output channel of the odometry: valid/ready handshake with one result per beat.
// Depends on ddo_pkg for the payload type.
interface ddo_result_if;
  logic             valid;
  logic             ready;
  ddo_pkg::result_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

>>> hdl/ddo_serial_mul.sv
// Bit-serial signed multiplier: sign and magnitude, one multiplier bit per cycle.
// No package dependencies; instantiated by the odometry top level.
module ddo_serial_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [33:0] a,
  input  logic signed [32:0] b,
  output logic               done,
  output logic               neg,
  output logic [65:0]        mag
);

  logic [32:0] mcand;
  logic [66:0] acc;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] a_neg;
  logic [32:0] b_neg;
  logic [32:0] a_mag;
  logic [32:0] b_mag;
  logic [33:0] sum;
  logic [67:0] shifted;

  assign a_neg = -a;
  assign b_neg = -b;
  assign a_mag = a[33] ? a_neg[32:0] : a[32:0];
  assign b_mag = b[32] ? b_neg : b;
  assign sum = acc[66:33] + (acc[0] ? {1'b0, mcand} : 34'd0);
  assign shifted = {sum, acc[32:0]} >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd32) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a_mag;
      acc   <= {34'd0, b_mag};
      neg   <= a[33] ^ b[32];
    end else if (busy) begin
      acc <= shifted[66:0];
    end
  end

  assign mag = acc[65:0];

endmodule

>>> hdl/ddo_serial_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependencies; instantiated by the odometry top level.
module ddo_serial_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [51:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [51:0] quo,
  output logic [31:0] rem
);

  logic [31:0] d;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] t;
  logic [32:0] diff;
  logic        ge;

  assign t    = {rem, quo[51]};
  assign ge   = t >= {1'b0, d};
  assign diff = t - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd51) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d   <= den;
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : t[31:0];
      quo <= {quo[50:0], ge};
    end
  end

endmodule

>>> hdl/differential_drive_odometry.sv
// Differential drive wheel odometry: sequencer, CORDIC and pose state.
// Depends on ddo_pkg, ddo_sample_if, ddo_result_if, ddo_serial_mul, ddo_serial_div.
//
//   Channel    Dir  Beat contents
//   sample_ch  in   command, left_count, right_count, time_stamp
//   result_ch  out  pos_x/y, heading, four speeds, status
//   cfg_*      in   register write (meters_per_tick, inv_wheel_base), never stalls
//
// Init and rejected counts go straight from decode to emit, no motion after
// the right wheel product. A full update runs 13 products on one bit-serial
// multiplier and 6 quotients on one bit-serial divider, plus two CORDIC runs
// of CORDIC_STEPS iterations.
// Reset is synchronous and restores the register defaults and a zero pose.
// A new beat is taken while the previous result waits; the last step holds
// only while that result is still untaken.
`include "assert_macros.svh"
module differential_drive_odometry (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ddo_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]   cfg_data,
  ddo_sample_if.sink                       sample_ch,
  ddo_result_if.source                     result_ch
);

  ddo_pkg::state_t  state;
  ddo_pkg::state_t  state_next;
  logic             first;
  ddo_pkg::sample_t item;
  ddo_pkg::status_t status;
  ddo_pkg::result_t out_item;
  logic             out_valid;

  logic [31:0]        mpt;
  logic [23:0]        iwb;
  logic signed [31:0] last_left;
  logic signed [31:0] last_right;
  logic [31:0]        last_time;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic signed [31:0] acc_heading;
  logic signed [31:0] held_speed_linear;
  logic signed [31:0] held_speed_angular;
  logic signed [31:0] held_speed_x;
  logic signed [31:0] held_speed_y;

  logic [31:0]        dt;
  logic signed [31:0] dl;
  logic signed [31:0] dr;
  logic signed [31:0] dth;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] cd;
  logic signed [31:0] sd;
  logic signed [31:0] ch;
  logic signed [31:0] sh;
  logic signed [39:0] tsum;

  logic signed [34:0]              cx;
  logic signed [34:0]              cy;
  logic signed [34:0]              cz;
  logic [ddo_pkg::STEP_W-1:0]      cstep;
  logic                            cneg;

  logic               mul_start;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic               mul_done;
  logic               mul_neg;
  logic [65:0]        mul_mag;
  logic               div_start;
  logic [51:0]        div_num;
  logic [31:0]        div_den;
  logic               div_done;
  logic [51:0]        div_quo;
  logic [31:0]        div_rem;

  logic               invalid;
  logic signed [31:0] trunc16;
  logic signed [31:0] quo_sat;
  logic signed [66:0] prod_s;
  logic signed [36:0] f30;
  logic signed [32:0] mean_sum;
  logic signed [32:0] mean_half;
  logic signed [31:0] mean_c;
  logic signed [31:0] ang;
  logic [32:0]        ang_neg;
  logic [31:0]        ang_mag;
  logic signed [20:0] r0;
  logic signed [20:0] r1;
  logic signed [34:0] z0;
  logic signed [34:0] z_fold;
  logic               fold;
  logic signed [34:0] xs;
  logic signed [34:0] ys;
  logic signed [34:0] at;
  logic signed [34:0] xn;
  logic signed [34:0] yn;
  logic signed [34:0] zn;
  logic signed [34:0] x_out;
  logic signed [34:0] y_out;
  logic               rot_last;

  ddo_serial_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .neg   (mul_neg),
    .mag   (mul_mag)
  );

  ddo_serial_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign invalid = (item.left_count == 32'sd0) || (item.left_count == ddo_pkg::COUNT_MAX) ||
                   (item.right_count == 32'sd0) || (item.right_count == ddo_pkg::COUNT_MAX);

  assign trunc16 = ddo_pkg::sat_mag(mul_neg, {2'b00, mul_mag[65:16]});
  assign quo_sat = ddo_pkg::sat_mag(mul_neg, div_quo);
  assign prod_s  = mul_neg ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});
  assign f30     = prod_s[66:30];

  assign mean_sum  = 33'(dl) + 33'(dr);
  assign mean_half = (mean_sum + $signed({32'd0, mean_sum[32]})) >>> 1;
  assign mean_c    = mean_half[31:0];

  // angle reduction after the modulo divide
  assign ang     = (state == ddo_pkg::ST_MOD_H) ? acc_heading : dth;
  assign ang_neg = -{ang[31], ang};
  assign ang_mag = ang[31] ? ang_neg[31:0] : ang[31:0];
  assign r0 = ang[31] ? -$signed({2'b00, div_rem[18:0]}) : $signed({2'b00, div_rem[18:0]});

  always_comb begin
    if (r0 > ddo_pkg::PI_Q16) begin
      r1 = r0 - ddo_pkg::TWO_PI_Q16_S;
    end else if (r0 < -ddo_pkg::PI_Q16) begin
      r1 = r0 + ddo_pkg::TWO_PI_Q16_S;
    end else begin
      r1 = r0;
    end
    z0 = 35'(r1) <<< 14;
    if (z0 > ddo_pkg::HALF_PI_Q30) begin
      z_fold = z0 - ddo_pkg::PI_Q30;
      fold   = 1'b1;
    end else if (z0 < -ddo_pkg::HALF_PI_Q30) begin
      z_fold = z0 + ddo_pkg::PI_Q30;
      fold   = 1'b1;
    end else begin
      z_fold = z0;
      fold   = 1'b0;
    end
  end

  // one CORDIC iteration
  always_comb begin
    xs = cx >>> cstep;
    ys = cy >>> cstep;
    at = $signed({5'd0, ddo_pkg::atan_q30(5'(cstep))});
    if (!cz[34]) begin
      xn = cx - ys;
      yn = cy + xs;
      zn = cz - at;
    end else begin
      xn = cx + ys;
      yn = cy - xs;
      zn = cz + at;
    end
    x_out = cneg ? -xn : xn;
    y_out = cneg ? -yn : yn;
  end

  assign rot_last = (cstep == ddo_pkg::STEP_W'(ddo_pkg::CORDIC_STEPS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ddo_pkg::ST_IDLE:   if (sample_ch.valid) state_next = ddo_pkg::ST_DECODE;
      ddo_pkg::ST_DECODE: begin
        if (item.command || invalid) state_next = ddo_pkg::ST_EMIT;
        else state_next = ddo_pkg::ST_DL;
      end
      ddo_pkg::ST_DL:     if (mul_done) state_next = ddo_pkg::ST_DR;
      ddo_pkg::ST_DR: begin
        if (mul_done) begin
          if (dl == 32'sd0 && trunc16 == 32'sd0) state_next = ddo_pkg::ST_EMIT;
          else state_next = ddo_pkg::ST_DTH;
        end
      end
      ddo_pkg::ST_DTH: begin
        if (mul_done) begin
          if (dt != 32'd0) state_next = ddo_pkg::ST_LIN_M;
          else if (mean_c != 32'sd0) state_next = ddo_pkg::ST_MOD_D;
          else state_next = ddo_pkg::ST_HEAD;
        end
      end
      ddo_pkg::ST_LIN_M:  if (mul_done) state_next = ddo_pkg::ST_LIN_D;
      ddo_pkg::ST_LIN_D:  if (div_done) state_next = ddo_pkg::ST_ANG_M;
      ddo_pkg::ST_ANG_M:  if (mul_done) state_next = ddo_pkg::ST_ANG_D;
      ddo_pkg::ST_ANG_D: begin
        if (div_done) begin
          if (mean_c != 32'sd0) state_next = ddo_pkg::ST_MOD_D;
          else state_next = ddo_pkg::ST_HEAD;
        end
      end
      ddo_pkg::ST_MOD_D:  if (div_done) state_next = ddo_pkg::ST_ROT_D;
      ddo_pkg::ST_ROT_D:  if (rot_last) state_next = ddo_pkg::ST_MOD_H;
      ddo_pkg::ST_MOD_H:  if (div_done) state_next = ddo_pkg::ST_ROT_H;
      ddo_pkg::ST_ROT_H:  if (rot_last) state_next = ddo_pkg::ST_DX;
      ddo_pkg::ST_DX:     if (mul_done) state_next = ddo_pkg::ST_DY;
      ddo_pkg::ST_DY: begin
        if (mul_done) begin
          if (dt != 32'd0) state_next = ddo_pkg::ST_SX_M;
          else state_next = ddo_pkg::ST_PXC;
        end
      end
      ddo_pkg::ST_SX_M:   if (mul_done) state_next = ddo_pkg::ST_SX_D;
      ddo_pkg::ST_SX_D:   if (div_done) state_next = ddo_pkg::ST_SY_M;
      ddo_pkg::ST_SY_M:   if (mul_done) state_next = ddo_pkg::ST_SY_D;
      ddo_pkg::ST_SY_D:   if (div_done) state_next = ddo_pkg::ST_PXC;
      ddo_pkg::ST_PXC:    if (mul_done) state_next = ddo_pkg::ST_PXS;
      ddo_pkg::ST_PXS:    if (mul_done) state_next = ddo_pkg::ST_PYS;
      ddo_pkg::ST_PYS:    if (mul_done) state_next = ddo_pkg::ST_PYC;
      ddo_pkg::ST_PYC:    if (mul_done) state_next = ddo_pkg::ST_HEAD;
      ddo_pkg::ST_HEAD:   state_next = ddo_pkg::ST_EMIT;
      ddo_pkg::ST_EMIT:   if (!out_valid || result_ch.ready) state_next = ddo_pkg::ST_IDLE;
      default:            state_next = ddo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sample_ch.ready = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = dt;
    unique case (state)
      ddo_pkg::ST_IDLE: sample_ch.ready = 1'b1;
      ddo_pkg::ST_DL: begin
        mul_start = first;
        mul_a = 34'(item.left_count) - 34'(last_left);
        mul_b = $signed({1'b0, mpt});
      end
      ddo_pkg::ST_DR: begin
        mul_start = first;
        mul_a = 34'(item.right_count) - 34'(last_right);
        mul_b = $signed({1'b0, mpt});
      end
      ddo_pkg::ST_DTH: begin
        mul_start = first;
        mul_a = 34'(dr) - 34'(dl);
        mul_b = $signed({9'd0, iwb});
      end
      ddo_pkg::ST_LIN_M: begin
        mul_start = first;
        mul_a = 34'(mean_c);
        mul_b = ddo_pkg::US_PER_S;
      end
      ddo_pkg::ST_ANG_M: begin
        mul_start = first;
        mul_a = 34'(dth);
        mul_b = ddo_pkg::US_PER_S;
      end
      ddo_pkg::ST_SX_M: begin
        mul_start = first;
        mul_a = 34'(dx);
        mul_b = ddo_pkg::US_PER_S;
      end
      ddo_pkg::ST_SY_M: begin
        mul_start = first;
        mul_a = 34'(dy);
        mul_b = ddo_pkg::US_PER_S;
      end
      ddo_pkg::ST_LIN_D, ddo_pkg::ST_ANG_D, ddo_pkg::ST_SX_D, ddo_pkg::ST_SY_D: begin
        div_start = first;
        div_num   = mul_mag[51:0];
      end
      ddo_pkg::ST_MOD_D, ddo_pkg::ST_MOD_H: begin
        div_start = first;
        div_num   = {20'd0, ang_mag};
        div_den   = ddo_pkg::TWO_PI_Q16;
      end
      ddo_pkg::ST_DX: begin
        mul_start = first;
        mul_a = 34'(mean_c);
        mul_b = 33'(cd);
      end
      ddo_pkg::ST_DY: begin
        mul_start = first;
        mul_a = 34'(mean_c);
        mul_b = 33'(sd);
      end
      ddo_pkg::ST_PXC: begin
        mul_start = first;
        mul_a = 34'(dx);
        mul_b = 33'(ch);
      end
      ddo_pkg::ST_PXS: begin
        mul_start = first;
        mul_a = 34'(dy);
        mul_b = 33'(sh);
      end
      ddo_pkg::ST_PYS: begin
        mul_start = first;
        mul_a = 34'(dx);
        mul_b = 33'(sh);
      end
      ddo_pkg::ST_PYC: begin
        mul_start = first;
        mul_a = 34'(dy);
        mul_b = 33'(ch);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ddo_pkg::ST_IDLE;
      first     <= 1'b0;
      out_valid <= 1'b0;
      mpt       <= ddo_pkg::MPT_RESET;
      iwb       <= ddo_pkg::IWB_RESET;
    end else begin
      state <= state_next;
      first <= (state_next != state);
      if (state == ddo_pkg::ST_EMIT && (!out_valid || result_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (ddo_pkg::cfg_reg_t'(cfg_index))
          ddo_pkg::REG_METERS_PER_TICK: mpt <= cfg_data;
          ddo_pkg::REG_INV_WHEEL_BASE:  iwb <= cfg_data[23:0];
          default: ;
        endcase
      end
    end
  end

  // pose and speed state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_left          <= '0;
      last_right         <= '0;
      last_time          <= '0;
      acc_x              <= '0;
      acc_y              <= '0;
      acc_heading        <= '0;
      held_speed_linear  <= '0;
      held_speed_angular <= '0;
      held_speed_x       <= '0;
      held_speed_y       <= '0;
      status             <= ddo_pkg::STATUS_UPDATED;
    end else begin
      unique case (state)
        ddo_pkg::ST_DECODE: begin
          status <= ddo_pkg::STATUS_UPDATED;
          if (item.command) begin
            last_left          <= '0;
            last_right         <= '0;
            last_time          <= item.time_stamp;
            acc_x              <= '0;
            acc_y              <= '0;
            acc_heading        <= '0;
            held_speed_linear  <= '0;
            held_speed_angular <= '0;
            held_speed_x       <= '0;
            held_speed_y       <= '0;
          end else if (invalid) begin
            status <= ddo_pkg::STATUS_INVALID;
          end
        end
        ddo_pkg::ST_DR: begin
          if (mul_done) begin
            last_left  <= item.left_count;
            last_right <= item.right_count;
            last_time  <= item.time_stamp;
            if (dl == 32'sd0 && trunc16 == 32'sd0) begin
              held_speed_linear  <= '0;
              held_speed_angular <= '0;
              held_speed_x       <= '0;
              held_speed_y       <= '0;
              status             <= ddo_pkg::STATUS_NO_MOTION;
            end
          end
        end
        ddo_pkg::ST_DTH: begin
          if (mul_done && dt == 32'd0) status <= ddo_pkg::STATUS_ZERO_DT;
        end
        ddo_pkg::ST_LIN_D: if (div_done) held_speed_linear <= quo_sat;
        ddo_pkg::ST_ANG_D: if (div_done) held_speed_angular <= quo_sat;
        ddo_pkg::ST_SX_D:  if (div_done) held_speed_x <= quo_sat;
        ddo_pkg::ST_SY_D:  if (div_done) held_speed_y <= quo_sat;
        ddo_pkg::ST_PXS:   if (mul_done) acc_x <= ddo_pkg::sat32_s(tsum - 40'(f30));
        ddo_pkg::ST_PYC:   if (mul_done) acc_y <= ddo_pkg::sat32_s(tsum + 40'(f30));
        ddo_pkg::ST_HEAD:  acc_heading <= ddo_pkg::sat32_s(40'(acc_heading) + 40'(dth));
        default: ;
      endcase
    end
  end

  // working values of one update
  always_ff @(posedge clk) begin
    if (state == ddo_pkg::ST_IDLE && sample_ch.valid) item <= sample_ch.item;
    if (state == ddo_pkg::ST_DECODE) dt <= item.time_stamp - last_time;
    if (mul_done) begin
      unique case (state)
        ddo_pkg::ST_DL:  dl <= trunc16;
        ddo_pkg::ST_DR:  dr <= trunc16;
        ddo_pkg::ST_DTH: dth <= trunc16;
        ddo_pkg::ST_DX:  dx <= ddo_pkg::sat32_s(40'(f30));
        ddo_pkg::ST_DY:  dy <= ddo_pkg::sat32_s(-40'(f30));
        ddo_pkg::ST_PXC: tsum <= 40'(acc_x) + 40'(f30);
        ddo_pkg::ST_PYS: tsum <= 40'(acc_y) + 40'(f30);
        default: ;
      endcase
    end
    if (div_done && (state == ddo_pkg::ST_MOD_D || state == ddo_pkg::ST_MOD_H)) begin
      cx    <= ddo_pkg::GAIN_Q30;
      cy    <= '0;
      cz    <= z_fold;
      cneg  <= fold;
      cstep <= '0;
    end else if (state == ddo_pkg::ST_ROT_D || state == ddo_pkg::ST_ROT_H) begin
      cx    <= xn;
      cy    <= yn;
      cz    <= zn;
      cstep <= cstep + 1'b1;
    end
    if (rot_last && state == ddo_pkg::ST_ROT_D) begin
      cd <= x_out[31:0];
      sd <= y_out[31:0];
    end
    if (rot_last && state == ddo_pkg::ST_ROT_H) begin
      ch <= x_out[31:0];
      sh <= y_out[31:0];
    end
    if (state == ddo_pkg::ST_EMIT && (!out_valid || result_ch.ready)) begin
      out_item.pos_x         <= acc_x;
      out_item.pos_y         <= acc_y;
      out_item.heading       <= acc_heading;
      out_item.speed_linear  <= held_speed_linear;
      out_item.speed_angular <= held_speed_angular;
      out_item.speed_x       <= held_speed_x;
      out_item.speed_y       <= held_speed_y;
      out_item.status        <= status;
    end
  end

  assign result_ch.valid = out_valid;
  assign result_ch.item  = out_item;

  `ASSERT_AT(a_reject_keeps_state, clk, rst, (state == ddo_pkg::ST_DECODE && !item.command && invalid) |=> ($stable(acc_heading) && $stable(last_time) && state == ddo_pkg::ST_EMIT))
  `ASSERT_NEVER(a_units_exclusive, clk, rst, mul_start && div_start)
  `ASSERT_AT(a_idle_units_quiet, clk, rst, (state == ddo_pkg::ST_IDLE) |-> (!mul_done && !div_done))

endmodule
